### src/cosr_pkg.sv
package cosr_pkg;

	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_READ    = 2'd1,
		OP_RESTART = 2'd2,
		OP_NONE    = 2'd3
	} opcode_t;

	typedef enum logic [4:0] {
		PH_LEFT  = 5'b00001,
		PH_DOWN  = 5'b00010,
		PH_RIGHT = 5'b00100,
		PH_UP    = 5'b01000,
		PH_TOP   = 5'b10000
	} phase_t;

	localparam logic [3:0] ORDER_RESET = 4'd1;
	localparam logic       REG_ORDER   = 1'b0;

	typedef logic signed [5:0] pos_t;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [3:0]         row_index;
		logic [3:0]         col_index;
		logic signed [31:0] element_value;
	} in_word_t;

	typedef struct packed {
		logic [3:0]         out_row;
		logic [3:0]         out_col;
		logic signed [31:0] out_value;
		logic               is_last;
	} out_word_t;

	typedef struct packed {
		pos_t row;
		pos_t col;
		logic last;
	} step_t;

endpackage

### src/cosr_ram.sv
module cosr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/cosr_walk.sv
module cosr_walk (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [2:0]     k,
	input  logic           restart,
	input  logic           step,
	output cosr_pkg::step_t cur
);

	cosr_pkg::pos_t   right_q, top_q, left_q, down_q, walk_q;
	logic [3:0]       rings_q;
	cosr_pkg::phase_t phase_q;

	cosr_pkg::pos_t   kp;
	cosr_pkg::phase_t eff_phase;
	logic             at_top;

	assign kp = cosr_pkg::pos_t'({3'b000, k});
	assign at_top = (phase_q == cosr_pkg::PH_LEFT) && (rings_q >= {1'b0, k});
	assign eff_phase = at_top ? cosr_pkg::PH_TOP : phase_q;

	always_comb begin
		cur = '0;
		unique case (eff_phase)
			cosr_pkg::PH_LEFT: begin
				cur.row = top_q;
				cur.col = walk_q;
			end
			cosr_pkg::PH_DOWN: begin
				cur.row = walk_q;
				cur.col = left_q;
			end
			cosr_pkg::PH_RIGHT: begin
				cur.row = down_q;
				cur.col = walk_q;
			end
			cosr_pkg::PH_UP: begin
				cur.row = walk_q;
				cur.col = right_q;
			end
			cosr_pkg::PH_TOP: begin
				cur.row  = top_q;
				cur.col  = walk_q;
				cur.last = (walk_q <= 6'sd0);
			end
			default: begin
				cur = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_q <= 6'sd0;
			top_q   <= 6'sd0;
			left_q  <= -6'sd1;
			down_q  <= 6'sd1;
			walk_q  <= 6'sd0;
			rings_q <= '0;
			phase_q <= cosr_pkg::PH_LEFT;
		end else if (restart || (step && cur.last)) begin
			right_q <= kp;
			top_q   <= kp;
			left_q  <= kp - 6'sd1;
			down_q  <= kp + 6'sd1;
			walk_q  <= kp;
			rings_q <= '0;
			phase_q <= cosr_pkg::PH_LEFT;
		end else if (step) begin
			unique case (eff_phase)
				cosr_pkg::PH_LEFT: begin
					if (walk_q - 6'sd1 > left_q) begin
						walk_q <= walk_q - 6'sd1;
					end else begin
						right_q <= right_q + 6'sd1;
						walk_q  <= top_q;
						phase_q <= cosr_pkg::PH_DOWN;
					end
				end
				cosr_pkg::PH_DOWN: begin
					if (walk_q + 6'sd1 < down_q) begin
						walk_q <= walk_q + 6'sd1;
					end else begin
						top_q   <= top_q - 6'sd1;
						walk_q  <= left_q;
						phase_q <= cosr_pkg::PH_RIGHT;
					end
				end
				cosr_pkg::PH_RIGHT: begin
					if (walk_q + 6'sd1 < right_q) begin
						walk_q <= walk_q + 6'sd1;
					end else begin
						left_q  <= left_q - 6'sd1;
						walk_q  <= down_q;
						phase_q <= cosr_pkg::PH_UP;
					end
				end
				cosr_pkg::PH_UP: begin
					if (walk_q - 6'sd1 > top_q) begin
						walk_q <= walk_q - 6'sd1;
					end else begin
						down_q  <= down_q + 6'sd1;
						rings_q <= rings_q + 4'd1;
						walk_q  <= right_q;
						phase_q <= cosr_pkg::PH_LEFT;
					end
				end
				cosr_pkg::PH_TOP: begin
					// run the top row right to left; last element restarts above
					walk_q  <= walk_q - 6'sd1;
					phase_q <= cosr_pkg::PH_TOP;
				end
				default: begin
					phase_q <= cosr_pkg::PH_LEFT;
				end
			endcase
		end
	end

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !restart && cur.last) |=>
			(phase_q == cosr_pkg::PH_LEFT && rings_q == 4'd0 && walk_q == right_q))
		else $error("walk did not restart after last element");

	a_rings_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		$past(restart) |-> (rings_q == 4'd0 && left_q < right_q && top_q < down_q))
		else $error("restart left walk state inconsistent");

	a_top_row_floor: assert property (@(posedge clk) disable iff (!arst_n)
		top_q >= 6'sd0)
		else $error("top bound went below row zero");

endmodule

### src/center_out_spiral_reader.sv
// A read-next item's result is registered and shows during the cycle after the item is accepted.
// Throughput: one item per cycle; busy stays low, the walk counters and one store read per item.
// Write and restart items give no result.
// Reset: matrix_order returns to 1 and the walk restarts; the element store keeps no reset
// value and holds whatever was last written.
module center_out_spiral_reader #(
	parameter int MAX_ORDER = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  cosr_pkg::in_word_t  item,
	output logic                result_valid,
	output cosr_pkg::out_word_t result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int DEPTH = MAX_ORDER * MAX_ORDER;
	localparam int AW    = $clog2(DEPTH);

	function automatic logic [AW-1:0] addr_of(input logic [3:0] r, input logic [3:0] c);
		return AW'(r) * AW'(MAX_ORDER) + AW'(c);
	endfunction

	logic [3:0]      order_q;
	logic [3:0]      order_d;
	logic [2:0]      k;
	logic            cfg_wr;
	logic            accept;
	logic            do_read;
	logic            do_write;
	logic            do_restart;
	cosr_pkg::step_t cur;
	logic            rd_in_range;
	logic [31:0]     rdata;

	logic            valid_s1;
	logic [3:0]      row_s1;
	logic [3:0]      col_s1;
	logic            last_s1;
	logic            in_range_s1;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign accept = start && !busy;

	assign do_read    = accept && (item.opcode == cosr_pkg::OP_READ);
	assign do_restart = accept && (item.opcode == cosr_pkg::OP_RESTART);
	// drop writes that fall outside the store
	assign do_write   = accept && (item.opcode == cosr_pkg::OP_WRITE) &&
		(int'(item.row_index) < MAX_ORDER) && (int'(item.col_index) < MAX_ORDER);

	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == cosr_pkg::REG_ORDER);
	assign prdata = (paddr[2] == cosr_pkg::REG_ORDER) ? {28'd0, order_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= cosr_pkg::ORDER_RESET;
		end else if (cfg_wr) begin
			order_q <= pwdata[3:0];
		end
	end

	// restart on a register write from the incoming order
	assign order_d = cfg_wr ? pwdata[3:0] : order_q;
	assign k = (order_d == 4'd0) ? 3'd0 : 3'((order_d - 4'd1) >> 1);

	cosr_walk u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.k       (k),
		.restart (do_restart || cfg_wr),
		.step    (do_read),
		.cur     (cur)
	);

	assign rd_in_range = (int'(cur.row) >= 0) && (int'(cur.row) < MAX_ORDER) &&
		(int'(cur.col) >= 0) && (int'(cur.col) < MAX_ORDER);

	cosr_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (do_write),
		.waddr (addr_of(item.row_index, item.col_index)),
		.wdata (item.element_value),
		.re    (do_read),
		.raddr (addr_of(cur.row[3:0], cur.col[3:0])),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= do_read;
		end
	end

	always_ff @(posedge clk) begin
		if (do_read) begin
			row_s1      <= cur.row[3:0];
			col_s1      <= cur.col[3:0];
			last_s1     <= cur.last;
			in_range_s1 <= rd_in_range;
		end
	end

	assign result_valid     = valid_s1;
	assign result.out_row   = row_s1;
	assign result.out_col   = col_s1;
	assign result.out_value = in_range_s1 ? rdata : 32'sd0;
	assign result.is_last   = last_s1;

	a_result_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start && !busy && item.opcode == cosr_pkg::OP_READ))
		else $error("result word without a read item");

	a_write_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		do_write |-> (int'(item.row_index) < MAX_ORDER && int'(item.col_index) < MAX_ORDER))
		else $error("store write outside matrix");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy == 1'b0)
		else $error("busy raised");

endmodule

### test/tb_center_out_spiral_reader.sv
module tb_center_out_spiral_reader;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          RANDOM_ITEMS = 860;
	localparam int          IDLE_LIMIT   = 400;
	localparam logic [2:0]  ORDER_ADDR   = 3'(4 * int'(cosr_pkg::REG_ORDER));

	typedef struct {
		bit                  is_cfg;
		logic [3:0]          order;
		cosr_pkg::in_word_t  w;
		bit                  known;
		cosr_pkg::out_word_t want;
	} plan_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	cosr_pkg::in_word_t  item = '0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [2:0]          paddr = '0;
	logic [31:0]         pwdata = '0;
	logic                busy;
	logic                result_valid;
	cosr_pkg::out_word_t result;
	logic [31:0]         prdata;
	logic                pready;

	center_out_spiral_reader dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_valid(result_valid),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// copy of the block's state
	logic [31:0]      store_copy [0:255];
	logic [3:0]       order_cfg;
	int               right_b, top_b, left_b, down_b, walk_pos, rings_done;
	cosr_pkg::phase_t walk_phase;

	cosr_pkg::out_word_t pending_elements[$];
	plan_row_t           directed_rows[$];
	cosr_pkg::out_word_t want_el;
	int          mismatch_count = 0;
	int          elements_seen = 0;
	int          walks_done = 0;
	int          order_writes = 0;
	int          items_sent = 0;
	int          burst_left = 0;
	int          idle_cycles = 0;

	function automatic int center_of_order();
		return (order_cfg == 4'd0) ? 0 : int'((order_cfg - 4'd1) >> 1);
	endfunction

	task automatic restart_walk();
		int k;
		k = center_of_order();
		right_b = k;
		top_b = k;
		left_b = k - 1;
		down_b = k + 1;
		walk_phase = cosr_pkg::PH_LEFT;
		walk_pos = k;
		rings_done = 0;
	endtask

	task automatic walk_step(output cosr_pkg::out_word_t el);
		int r, c;
		bit last;
		last = 1'b0;
		if (walk_phase == cosr_pkg::PH_LEFT && rings_done >= center_of_order())
			walk_phase = cosr_pkg::PH_TOP;
		case (walk_phase)
			cosr_pkg::PH_LEFT: begin
				r = top_b;
				c = walk_pos;
				if (walk_pos - 1 > left_b) begin
					walk_pos--;
				end else begin
					right_b++;
					walk_phase = cosr_pkg::PH_DOWN;
					walk_pos = top_b;
				end
			end
			cosr_pkg::PH_DOWN: begin
				r = walk_pos;
				c = left_b;
				if (walk_pos + 1 < down_b) begin
					walk_pos++;
				end else begin
					top_b--;
					walk_phase = cosr_pkg::PH_RIGHT;
					walk_pos = left_b;
				end
			end
			cosr_pkg::PH_RIGHT: begin
				r = down_b;
				c = walk_pos;
				if (walk_pos + 1 < right_b) begin
					walk_pos++;
				end else begin
					left_b--;
					walk_phase = cosr_pkg::PH_UP;
					walk_pos = down_b;
				end
			end
			cosr_pkg::PH_UP: begin
				r = walk_pos;
				c = right_b;
				if (walk_pos - 1 > top_b) begin
					walk_pos--;
				end else begin
					down_b++;
					rings_done++;
					walk_phase = cosr_pkg::PH_LEFT;
					walk_pos = right_b;
				end
			end
			default: begin
				// top row, right to left; the walk wraps after column zero
				r = top_b;
				c = walk_pos;
				if (walk_pos <= 0) begin
					last = 1'b1;
					restart_walk();
				end else begin
					walk_pos--;
				end
			end
		endcase
		el.out_row = 4'(r);
		el.out_col = 4'(c);
		el.out_value = (r >= 0 && r < 16 && c >= 0 && c < 16) ? store_copy[r * 16 + c] : '0;
		el.is_last = last;
	endtask

	task automatic apply_word(input cosr_pkg::in_word_t w, input bit known,
			input cosr_pkg::out_word_t want);
		cosr_pkg::out_word_t el;
		case (cosr_pkg::opcode_t'(w.opcode))
			cosr_pkg::OP_WRITE: store_copy[{w.row_index, w.col_index}] = w.element_value;
			cosr_pkg::OP_READ: begin
				walk_step(el);
				pending_elements.push_back(known ? want : el);
			end
			cosr_pkg::OP_RESTART: restart_walk();
			default: ;
		endcase
	endtask

	task automatic send_word(input cosr_pkg::in_word_t w, input bit known,
			input cosr_pkg::out_word_t want);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		item <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
		apply_word(w, known, want);
		items_sent++;
	endtask

	task automatic set_order(input logic [3:0] o);
		start <= 1'b0;
		while (pending_elements.size() != 0) @(posedge clk);
		// let a trailing write or restart settle
		repeat (2) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ORDER_ADDR;
		pwdata <= {28'd0, o};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		order_cfg = o;
		restart_walk();
		order_writes++;
	endtask

	function automatic cosr_pkg::in_word_t cmd(cosr_pkg::opcode_t op, logic [3:0] r,
			logic [3:0] c, logic [31:0] v);
		return {op, r, c, v};
	endfunction

	function automatic cosr_pkg::in_word_t random_word(bit restarts_ok);
		int pick;
		logic [31:0] v;
		cosr_pkg::opcode_t op;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			op = cosr_pkg::OP_READ;
		else if (pick < 94)
			op = cosr_pkg::OP_WRITE;
		else if (pick < 98 || !restarts_ok)
			op = cosr_pkg::OP_NONE;
		else
			op = cosr_pkg::OP_RESTART;
		case ($urandom_range(0, 11))
			0: v = 32'h8000_0000;
			1: v = 32'h7fff_ffff;
			2: v = 32'hffff_ffff;
			3: v = 32'h0000_0000;
			default: v = $urandom;
		endcase
		return cmd(op, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), v);
	endfunction

	task automatic add_cmd(cosr_pkg::opcode_t op, logic [3:0] r, logic [3:0] c,
			logic [31:0] v);
		plan_row_t row;
		row.is_cfg = 1'b0;
		row.order = '0;
		row.w = cmd(op, r, c, v);
		row.known = 1'b0;
		row.want = '0;
		directed_rows.push_back(row);
	endtask

	task automatic add_read_known(logic [3:0] r, logic [3:0] c, logic [31:0] v, logic l);
		plan_row_t row;
		row.is_cfg = 1'b0;
		row.order = '0;
		row.w = cmd(cosr_pkg::OP_READ, 4'd0, 4'd0, 32'd0);
		row.known = 1'b1;
		row.want = {r, c, v, l};
		directed_rows.push_back(row);
	endtask

	task automatic add_order(logic [3:0] o);
		plan_row_t row;
		row.is_cfg = 1'b1;
		row.order = o;
		row.w = '0;
		row.known = 1'b0;
		row.want = '0;
		directed_rows.push_back(row);
	endtask

	task automatic flag_mismatch(input string msg);
		if (mismatch_count < 40)
			$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (pending_elements.size() == 0) begin
				flag_mismatch($sformatf("element (%0d,%0d) with nothing pending",
					result.out_row, result.out_col));
			end else begin
				want_el = pending_elements.pop_front();
				if (result.out_row !== want_el.out_row)
					flag_mismatch($sformatf("out_row %0d, expected %0d",
						result.out_row, want_el.out_row));
				if (result.out_col !== want_el.out_col)
					flag_mismatch($sformatf("out_col %0d, expected %0d",
						result.out_col, want_el.out_col));
				if (result.out_value !== want_el.out_value)
					flag_mismatch($sformatf("out_value %0d at (%0d,%0d), expected %0d",
						result.out_value, want_el.out_row, want_el.out_col,
						want_el.out_value));
				if (result.is_last !== want_el.is_last)
					flag_mismatch($sformatf("is_last %b at (%0d,%0d), expected %b",
						result.is_last, want_el.out_row, want_el.out_col,
						want_el.is_last));
				elements_seen++;
				if (want_el.is_last)
					walks_done++;
			end
		end
	end

	// stop a hung run: count cycles with no word moving in either direction
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: %0d idle cycles, %0d elements pending",
				idle_cycles, pending_elements.size());
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int random_items;
		int span;
		int n;
		int phase_no;
		logic [3:0] o;
		cosr_pkg::in_word_t w;

		random_items = 0;
		order_cfg = cosr_pkg::ORDER_RESET;
		restart_walk();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the whole store so that no walk reads an unwritten entry
		for (n = 0; n < 256; n++)
			send_word(cmd(cosr_pkg::OP_WRITE, 4'(n >> 4), 4'(n), $urandom), 1'b0, '0);

		add_cmd(cosr_pkg::OP_WRITE, 4'd0, 4'd0, 32'h7fff_ffff);
		add_read_known(4'd0, 4'd0, 32'h7fff_ffff, 1'b1);
		add_read_known(4'd0, 4'd0, 32'h7fff_ffff, 1'b1);
		add_cmd(cosr_pkg::OP_WRITE, 4'd15, 4'd15, 32'h8000_0000);
		add_cmd(cosr_pkg::OP_WRITE, 4'd0, 4'd0, 32'h8000_0000);
		add_read_known(4'd0, 4'd0, 32'h8000_0000, 1'b1);
		add_cmd(cosr_pkg::OP_NONE, 4'd15, 4'd15, 32'hffff_ffff);
		add_cmd(cosr_pkg::OP_RESTART, 4'd15, 4'd15, 32'hffff_ffff);
		add_order(4'd3);
		// full order-3 walk plus one wrapped read
		for (n = 0; n < 10; n++)
			add_cmd(cosr_pkg::OP_READ, 4'd0, 4'd0, 32'd0);
		add_cmd(cosr_pkg::OP_READ, 4'd0, 4'd0, 32'd0);
		add_cmd(cosr_pkg::OP_RESTART, 4'd0, 4'd0, 32'd0);
		add_cmd(cosr_pkg::OP_READ, 4'd0, 4'd0, 32'd0);
		add_order(4'd0);
		add_read_known(4'd0, 4'd0, 32'h8000_0000, 1'b1);
		add_order(4'd15);
		add_cmd(cosr_pkg::OP_READ, 4'd0, 4'd0, 32'd0);
		add_cmd(cosr_pkg::OP_READ, 4'd0, 4'd0, 32'd0);
		add_order(4'd4);
		add_cmd(cosr_pkg::OP_READ, 4'd0, 4'd0, 32'd0);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg)
				set_order(directed_rows[i].order);
			else
				send_word(directed_rows[i].w, directed_rows[i].known, directed_rows[i].want);
		end

		phase_no = 0;
		while (random_items < RANDOM_ITEMS) begin
			case (phase_no)
				0: o = 4'd15;
				1: o = 4'd0;
				2: o = 4'd1;
				3: o = 4'd13;
				4: o = 4'd4;
				5: o = 4'd3;
				default: o = 4'($urandom_range(0, 15));
			endcase
			set_order(o);
			// large orders get long phases so whole walks complete
			span = (o >= 4'd11) ? 350 : $urandom_range(40, 120);
			n = 0;
			while (n < span && random_items < RANDOM_ITEMS) begin
				w = random_word(o < 4'd11);
				send_word(w, 1'b0, '0);
				if (w.opcode != cosr_pkg::OP_NONE) begin
					n++;
					random_items++;
				end
			end
			phase_no++;
		end
		start <= 1'b0;

		while (pending_elements.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		$display("covered %0d words over %0d order settings", items_sent, order_writes);
		$display("checked %0d spiral elements, %0d complete walks, %0d mismatches",
			elements_seen, walks_done, mismatch_count);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### sim.f
src/cosr_pkg.sv
src/cosr_ram.sv
src/cosr_walk.sv
src/center_out_spiral_reader.sv
test/tb_center_out_spiral_reader.sv
